// ===== sv/crc16_frame_checker_core_macros.svh =====
// Assertion macros used by the checker file of the frame checker.
`ifndef CRC16_FRAME_CHECKER_CORE_MACROS_SVH
`define CRC16_FRAME_CHECKER_CORE_MACROS_SVH

// Concurrent assertion, ignored while reset is high.
`define CFC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also runs through reset.
`define CFC_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/crc16fc_pkg.sv =====
// Types, constants and codes shared by the CRC-16 frame checker files.
package crc16fc_pkg;

   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_MSB     = 16'h8000;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [15:0] POLY_RESET  = 16'h1021;
   localparam logic [15:0] LIMIT_RESET = 16'd519;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_CRC_POLY      = 1'b0,
      CSR_MAX_FRAME_LEN = 1'b1
   } csr_index_type;

   // One received byte.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // One frame report.
   typedef struct packed {
      logic        frame_ok;
      logic        too_long;
      logic [15:0] frame_bytes;
   } rsp_type;

   // Live configuration handed to the frame stage.
   typedef struct packed {
      logic [15:0] crc_poly;
      logic [15:0] max_frame_len;
   } cfg_type;

   // Input register contents offered to the frame stage.
   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

endpackage

// ===== sv/crc16fc_crc_unit.sv =====
// Byte-wide CRC-16 update, MSB first, with a programmable polynomial.
module crc16fc_crc_unit (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   input  logic [15:0] crc_poly,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] c;
      c = crc_cur ^ {data_byte, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & crc16fc_pkg::CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ crc_poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

// ===== sv/crc16fc_frame_stage.sv =====
// Frame state (CRC and byte count) and the registered frame report.
module crc16fc_frame_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  crc16fc_pkg::stage_type stage,
   input  crc16fc_pkg::cfg_type  cfg,
   output logic                  stage_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output crc16fc_pkg::rsp_type  rsp_item
);

   logic [15:0]          crc_acc_ff, crc_acc_in;
   logic [15:0]          byte_count_ff, byte_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   crc16fc_pkg::rsp_type rsp_item_ff, rsp_item_in;
   logic [15:0]          crc_next;
   logic [15:0]          count_next;
   logic                 too_long;

   crc16fc_crc_unit u_crc (
      .crc_cur   (crc_acc_ff),
      .data_byte (stage.item.data_byte),
      .crc_poly  (cfg.crc_poly),
      .crc_next  (crc_next)
   );

   // A last byte needs a free report slot; other bytes always pass.
   assign stage_take = stage.valid &&
                       (!stage.item.last_byte || !rsp_valid_ff || !rsp_stall);

   assign count_next = (byte_count_ff == crc16fc_pkg::COUNT_MAX) ?
                       byte_count_ff : byte_count_ff + 16'd1;
   assign too_long   = count_next > cfg.max_frame_len;

   always_comb begin
      crc_acc_in    = crc_acc_ff;
      byte_count_in = byte_count_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (stage_take) begin
         if (stage.item.last_byte) begin
            crc_acc_in              = crc16fc_pkg::CRC_INIT;
            byte_count_in           = 16'd0;
            rsp_valid_in            = 1'b1;
            rsp_item_in.frame_ok    = !too_long && (crc_next == 16'h0000);
            rsp_item_in.too_long    = too_long;
            rsp_item_in.frame_bytes = count_next;
         end else begin
            crc_acc_in    = crc_next;
            byte_count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_acc_ff    <= crc16fc_pkg::CRC_INIT;
         byte_count_ff <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         crc_acc_ff    <= crc_acc_in;
         byte_count_ff <= byte_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== sv/crc16_frame_checker_core.sv =====
// Top level of the CRC-16 frame checker: input register, CSRs, frame stage.
//
// Usage:
//  - Request channel (req_valid, req_stall, req_item) carries one frame byte
//    per transaction; req_item.last_byte marks the final byte (CRC included).
//  - Response channel (rsp_valid, rsp_stall, rsp_item) carries one report per
//    frame: frame_ok, too_long and the saturating byte count.
//  - CSR port: csr_write with csr_index selects crc_poly or max_frame_len.
//    Write only while the block is idle.
//  - Throughput: one byte per cycle unless a held report blocks a last byte;
//    the 8-step CRC update is unrolled from input register to frame state.
//  - Report path: input register, then report register (rsp_valid, rsp_item).
//  - Stall: a held report blocks only the next last byte; plain bytes keep
//    flowing into the CRC. A blocked last byte holds in the input register
//    and req_stall rises until the report is taken.
//  - Reset: CRC returns to 0xFFFF, count to zero, polynomial to 0x1021,
//    limit to 519 bytes, and both channels go empty.
module crc16_frame_checker_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  crc16fc_pkg::req_type       req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output crc16fc_pkg::rsp_type       rsp_item,
   input  logic                       csr_write,
   input  crc16fc_pkg::csr_index_type csr_index,
   input  logic [15:0]                csr_wdata
);

   logic                 req_valid_ff, req_valid_in;
   crc16fc_pkg::req_type req_item_ff, req_item_in;
   crc16fc_pkg::cfg_type cfg_ff, cfg_in;
   crc16fc_pkg::stage_type stage;
   logic                 stage_take;
   logic                 req_accept;

   // Hold the input register while the frame stage refuses its byte.
   assign req_stall  = req_valid_ff && !stage_take;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff && !stage_take;
      req_item_in  = req_item_ff;
      if (req_accept) begin
         req_valid_in = 1'b1;
         req_item_in  = req_item;
      end
   end

   // Update the selected CSR; the write is registered in cfg_ff before the frame stage sees it.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            crc16fc_pkg::CSR_CRC_POLY:      cfg_in.crc_poly      = csr_wdata;
            crc16fc_pkg::CSR_MAX_FRAME_LEN: cfg_in.max_frame_len = csr_wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff         <= 1'b0;
         cfg_ff.crc_poly      <= crc16fc_pkg::POLY_RESET;
         cfg_ff.max_frame_len <= crc16fc_pkg::LIMIT_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         cfg_ff       <= cfg_in;
      end
      req_item_ff <= req_item_in;
   end

   assign stage.valid = req_valid_ff;
   assign stage.item  = req_item_ff;

   crc16fc_frame_stage u_frame (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .cfg        (cfg_ff),
      .stage_take (stage_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== sv/crc16fc_checker.sv =====
// Port-level assertions for the frame checker and their bind to the top level.
`include "crc16_frame_checker_core_macros.svh"

module crc16fc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input crc16fc_pkg::rsp_type rsp_item
);

   `CFC_ASSERT(a_reset_empties_rsp, clock, reset |=> !rsp_valid, "report after reset")
   `CFC_ASSERT_RST(a_ok_excludes_long, clock, reset,
      rsp_valid |-> !(rsp_item.frame_ok && rsp_item.too_long),
      "ok and too_long together")
   `CFC_ASSERT_RST(a_count_nonzero, clock, reset,
      rsp_valid |-> (rsp_item.frame_bytes != 16'd0),
      "empty frame reported")
   `CFC_ASSERT_RST(a_rsp_hold, clock, reset,
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)),
      "stalled report changed")

endmodule

bind crc16_frame_checker_core crc16fc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
